[sv/olb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order book level package
// Shared constants and types for the price-level book and deal detector.
// ----------------------------------------------------------------------------
package olb_pkg;

  localparam int unsigned PriceLevels = 64;
  localparam int unsigned SlotW       = $clog2(PriceLevels);
  localparam int unsigned CntW        = $clog2(PriceLevels + 1);

  localparam int unsigned InW  = 8 + 31 + 31 + 63 + 31 + 31 + 63 + 63;
  localparam int unsigned InTdataW  = ((InW + 7) / 8) * 8;
  localparam int unsigned OutW = 1 + 63 + 63 + 31 + 31 + 1 + 31 + 63 + 1 + 32 + 1;
  localparam int unsigned OutTdataW = ((OutW + 7) / 8) * 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input item
    logic clear;      // clear all valid bits
    logic scan;       // examine the entry at the scan index
    logic finish;     // compute and commit the result
  } olb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // scan index is at the last entry
    logic skip_scan;  // the item needs no table search
  } olb_sts_t;

endpackage

[sv/olb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order book level controller
// Sequences capture, table scan, commit and output handoff for each item.
// ----------------------------------------------------------------------------
module olb_ctrl import olb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  input  olb_sts_t sts_i,
  output olb_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StFlush,
    StDone,
    StOut
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  // The result register frees as soon as it is taken, so the next item may
  // be accepted in the same cycle.
  assign in_ready_o  = (state_q == StIdle) || (state_q == StOut && out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load   = in_valid_i && in_ready_o;
    cmd_o.scan   = (state_q == StScan);
    cmd_o.finish = (state_q == StDone);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StScan;
          end
        end
        StScan: begin
          if (sts_i.scan_last || sts_i.skip_scan) begin
            state_q <= StFlush;
          end
        end
        // The table read is registered, so the last entry is compared here.
        StFlush: begin
          state_q <= StDone;
        end
        StDone: begin
          state_q     <= StOut;
          out_valid_q <= 1'b1;
        end
        StOut: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= in_valid_i ? StScan : StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == StOut)
    else $error("result shown outside output state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == StScan)
    else $error("accepted item did not start a scan");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q)
    else $error("commit without a result");

endmodule

[sv/olb_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order book level datapath
// Level table, sequential price search, saturating update and deal detect.
// ----------------------------------------------------------------------------
module olb_dp import olb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic [InTdataW-1:0]  in_data_i,
  input  olb_cmd_t             cmd_i,
  output olb_sts_t             sts_o,
  output logic [OutTdataW-1:0] out_data_o
);

  logic [30:0] price_mem [PriceLevels];
  logic [31:0] qty_mem   [PriceLevels];
  logic [PriceLevels-1:0] valid_q;

  logic        use_book_q;
  logic [62:0] prev_tid_q;
  logic        qready_q;

  logic [7:0]  flags_q;
  logic [30:0] price_q, amount_q, tpx_q, oi_q;
  logic [62:0] tid_q, tm_q, key_q;

  logic [SlotW-1:0] idx_q;
  logic             hit_q, free_q;
  logic [SlotW-1:0] hit_slot_q, free_slot_q;
  logic [31:0]      hit_qty_q;

  // Registered table read; the compare runs in the cycle after the scan index names its entry.
  logic [30:0]      rd_price_q;
  logic [31:0]      rd_qty_q;
  logic [SlotW-1:0] cmp_idx_q;
  logic             cmp_v_q;

  logic [OutTdataW-1:0] out_q;

  logic        is_add, is_buy, is_sell, ignore;
  logic [7:0]  in_flags;

  assign in_flags = in_data_i[7:0];
  assign is_add   = flags_q[0];
  assign is_buy   = flags_q[1];
  assign is_sell  = flags_q[2];
  assign ignore   = (is_buy == is_sell) || flags_q[4] || flags_q[5];

  assign sts_o.scan_last = (idx_q == SlotW'(PriceLevels - 1));
  assign sts_o.skip_scan = ignore || !use_book_q;

  // Saturating signed update in 34 bits.
  logic signed [33:0] base, sum;
  logic signed [31:0] q_sat;
  logic               add_dir;
  assign base    = hit_q ? 34'(signed'(hit_qty_q)) : '0;
  assign add_dir = is_add ? is_sell : is_buy;
  assign sum     = add_dir ? base + 34'(amount_q) : base - 34'(amount_q);
  always_comb begin
    if (sum > 34'sh0_7FFF_FFFF) begin
      q_sat = 32'sh7FFF_FFFF;
    end else if (sum < -34'sh0_8000_0000) begin
      q_sat = 32'sh8000_0000;
    end else begin
      q_sat = sum[31:0];
    end
  end

  logic deal;
  assign deal = (prev_tid_q != '0) && (prev_tid_q == tid_q);

  always_ff @(posedge clk_i) begin
    rd_price_q <= price_mem[idx_q];
    rd_qty_q   <= qty_mem[idx_q];
    cmp_idx_q  <= idx_q;
    if (cmd_i.load) begin
      flags_q  <= in_data_i[7:0];
      price_q  <= in_data_i[38:8];
      amount_q <= in_data_i[69:39];
      tid_q    <= in_data_i[132:70];
      tpx_q    <= in_data_i[163:133];
      oi_q     <= in_data_i[194:164];
      tm_q     <= in_data_i[257:195];
      key_q    <= in_data_i[320:258];
      idx_q    <= '0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
    end else begin
      if (cmd_i.scan) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmp_v_q) begin
        if (valid_q[cmp_idx_q]) begin
          if (!hit_q && rd_price_q == price_q) begin
            hit_q      <= 1'b1;
            hit_slot_q <= cmp_idx_q;
            hit_qty_q  <= rd_qty_q;
          end
        end else if (!free_q) begin
          free_q      <= 1'b1;
          free_slot_q <= cmp_idx_q;
        end
      end
    end
    if (cmd_i.finish && !ignore && use_book_q && q_sat != '0) begin
      if (hit_q) begin
        qty_mem[hit_slot_q] <= q_sat;
      end else if (free_q) begin
        price_mem[free_slot_q] <= price_q;
        qty_mem[free_slot_q]   <= q_sat;
      end
    end
    if (cmd_i.finish) begin
      logic        full_v;
      logic [31:0] shown_v;
      logic        qr_v;
      full_v  = 1'b0;
      shown_v = '0;
      qr_v    = qready_q;
      if (!ignore && use_book_q) begin
        qr_v = flags_q[6];
        if (q_sat != '0) begin
          if (hit_q || free_q) begin
            shown_v = q_sat;
          end else begin
            full_v = 1'b1;
          end
        end
      end
      out_q <= '0;
      if (!ignore && deal) begin
        out_q[0]       <= 1'b1;
        out_q[63:1]    <= key_q;
        out_q[126:64]  <= tid_q;
        out_q[157:127] <= tpx_q;
        out_q[188:158] <= amount_q;
        out_q[189]     <= ~is_sell;
        out_q[220:190] <= oi_q;
        out_q[283:221] <= tm_q;
      end
      out_q[284]     <= qr_v;
      out_q[316:285] <= shown_v;
      out_q[317]     <= full_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      use_book_q <= 1'b0;
      prev_tid_q <= '0;
      qready_q   <= 1'b0;
      cmp_v_q    <= 1'b0;
    end else begin
      cmp_v_q <= cmd_i.scan;
      if (cfg_we_i) begin
        use_book_q <= cfg_wdata_i;
      end
      if (cmd_i.load && in_flags[3]) begin
        valid_q <= '0;
      end
      if (cmd_i.finish && !ignore) begin
        prev_tid_q <= tid_q;
        if (use_book_q) begin
          qready_q <= flags_q[6];
          if (q_sat == '0) begin
            if (hit_q) begin
              valid_q[hit_slot_q] <= 1'b0;
            end
          end else if (hit_q) begin
            valid_q[hit_slot_q] <= 1'b1;
          end else if (free_q) begin
            valid_q[free_slot_q] <= 1'b1;
          end
        end
      end
    end
  end

  assign out_data_o = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && hit_q |-> valid_q[hit_slot_q])
    else $error("hit slot not valid at commit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && free_q |-> !valid_q[free_slot_q])
    else $error("free slot already taken at commit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> !hit_q && !free_q)
    else $error("search state not cleared on load");

endmodule

[sv/order_log_level_book_and_deal_detect_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order log level book and deal detect top
// Keeps a signed quantity per price level and detects completed deals.
// ----------------------------------------------------------------------------
// Channel   | Direction | Handshake            | Payload
// s_axis    | in        | tvalid/tready        | order-log item, 321 bits
// m_axis    | out       | tvalid/tready        | result item, 318 bits
// cfg       | in        | cfg_we_i             | use_level_book, 1 bit
//
// With the level book enabled, each item is searched entry by entry through
// the level table, followed by a flush step for its registered read;
// ignored items and items with the book disabled skip the table search.
// Reset clears all level valid bits, the previous deal id and the
// quotes-ready flag at once; no clearing pass is needed.
// A held result stalls the block; the next item is taken as the result leaves.
// ----------------------------------------------------------------------------
module order_log_level_book_and_deal_detect_top import olb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata, low bit up: entry_flags, order_price, order_amount, trade_id,
  // trade_price, open_interest, entry_time, security_key, zero fill.
  input  logic [InTdataW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata, low bit up: deal_valid, deal_key, deal_number, deal_px, deal_qty,
  // deal_side, deal_oi, deal_time, quotes_ready, level_quantity, table_full.
  output logic [OutTdataW-1:0] m_axis_tdata
);

  olb_cmd_t cmd;
  olb_sts_t sts;

  // The controller owns the handshakes; the datapath owns table and result.
  olb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  olb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (m_axis_tdata)
  );

endmodule

[tb/olb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order book level checker
// Watches the config port and both streams, keeps its own copy of the price
// level table and deal id, and compares every result item field by field.
// ----------------------------------------------------------------------------
module olb_checker import olb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [OutTdataW-1:0] m_axis_tdata,
  output int                   pending_o,
  output int                   fail_count_o,
  output int                   deal_count_o,
  output int                   full_count_o
);

  typedef struct packed {
    logic [1:0]  pad;
    logic        table_full;
    logic [31:0] level_quantity;
    logic        quotes_ready;
    logic [62:0] deal_time;
    logic [30:0] deal_oi;
    logic        deal_side;
    logic [30:0] deal_qty;
    logic [30:0] deal_px;
    logic [62:0] deal_number;
    logic [62:0] deal_key;
    logic        deal_valid;
  } book_result_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic [62:0] security_key;
    logic [62:0] entry_time;
    logic [30:0] open_interest;
    logic [30:0] trade_price;
    logic [62:0] trade_id;
    logic [30:0] order_amount;
    logic [30:0] order_price;
    logic [7:0]  entry_flags;
  } book_entry_t;

  logic [30:0] lvl_px  [PriceLevels];
  logic [31:0] lvl_qty [PriceLevels];
  logic        lvl_vld [PriceLevels];
  logic [62:0] last_tid;
  logic        qr_flag;
  logic        book_on;
  book_result_t expected_q[$];

  assign pending_o = expected_q.size();

  // Applies one entry to the model table and returns the result it causes.
  function automatic book_result_t apply_entry(book_entry_t e);
    book_result_t r;
    int hit, spare;
    longint q;
    logic buy, sell;
    r = '0;
    hit = -1;
    spare = -1;
    buy = e.entry_flags[1];
    sell = e.entry_flags[2];
    if (e.entry_flags[3]) begin
      for (int i = 0; i < PriceLevels; i++) lvl_vld[i] = 1'b0;
    end
    if (buy == sell || e.entry_flags[5:4] != 2'b00) begin
      r.quotes_ready = qr_flag;
      return r;
    end
    if (book_on) begin
      for (int i = 0; i < PriceLevels; i++) begin
        if (lvl_vld[i]) begin
          if (hit < 0 && lvl_px[i] == e.order_price) hit = i;
        end else if (spare < 0) begin
          spare = i;
        end
      end
      q = (hit >= 0) ? longint'($signed(lvl_qty[hit])) : 0;
      // Add-sell and remove-buy raise the level, the other two lower it.
      if (e.entry_flags[0] ? sell : buy) q += longint'(e.order_amount);
      else q -= longint'(e.order_amount);
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      if (q == 0) begin
        if (hit >= 0) lvl_vld[hit] = 1'b0;
      end else if (hit >= 0) begin
        lvl_qty[hit] = q[31:0];
        r.level_quantity = q[31:0];
      end else if (spare >= 0) begin
        lvl_vld[spare] = 1'b1;
        lvl_px[spare] = e.order_price;
        lvl_qty[spare] = q[31:0];
        r.level_quantity = q[31:0];
      end else begin
        r.table_full = 1'b1;
      end
      qr_flag = e.entry_flags[6];
    end
    if (last_tid != '0 && last_tid == e.trade_id) begin
      r.deal_valid = 1'b1;
      r.deal_key = e.security_key;
      r.deal_number = e.trade_id;
      r.deal_px = e.trade_price;
      r.deal_qty = e.order_amount;
      r.deal_side = ~sell;
      r.deal_oi = e.open_interest;
      r.deal_time = e.entry_time;
    end
    last_tid = e.trade_id;
    r.quotes_ready = qr_flag;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      if (fail_count_o < 10)
        $display("%0t: mismatch on %s: expected %0h, got %0h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    book_result_t got, exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < PriceLevels; i++) lvl_vld[i] = 1'b0;
      last_tid = '0;
      qr_flag = 1'b0;
      book_on = 1'b0;
      expected_q.delete();
      fail_count_o = 0;
      deal_count_o = 0;
      full_count_o = 0;
    end else begin
      if (cfg_we_i) book_on = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        exp_r = apply_entry(book_entry_t'(s_axis_tdata));
        expected_q.push_back(exp_r);
        deal_count_o += exp_r.deal_valid;
        full_count_o += exp_r.table_full;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = book_result_t'(m_axis_tdata);
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("%0t: result item with none expected", $time);
          fail_count_o++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("deal_valid", exp_r.deal_valid, got.deal_valid);
          check_field("deal_key", exp_r.deal_key, got.deal_key);
          check_field("deal_number", exp_r.deal_number, got.deal_number);
          check_field("deal_px", exp_r.deal_px, got.deal_px);
          check_field("deal_qty", exp_r.deal_qty, got.deal_qty);
          check_field("deal_side", exp_r.deal_side, got.deal_side);
          check_field("deal_oi", exp_r.deal_oi, got.deal_oi);
          check_field("deal_time", exp_r.deal_time, got.deal_time);
          check_field("quotes_ready", exp_r.quotes_ready, got.quotes_ready);
          check_field("level_quantity", exp_r.level_quantity, got.level_quantity);
          check_field("table_full", exp_r.table_full, got.table_full);
          check_field("pad", exp_r.pad, got.pad);
        end
      end
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order book level testbench top
// Drives order-log items and config writes into the block, idles both
// streams at random and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
  import olb_pkg::*;

  // Entry flag bits.
  localparam logic [7:0] FL_ADD  = 8'h01;
  localparam logic [7:0] FL_BUY  = 8'h02;
  localparam logic [7:0] FL_SELL = 8'h04;
  localparam logic [7:0] FL_SESS = 8'h08;
  localparam logic [7:0] FL_NSYS = 8'h10;
  localparam logic [7:0] FL_REPL = 8'h20;
  localparam logic [7:0] FL_EOT  = 8'h40;
  localparam logic [7:0] FL_FILL = 8'h80;
  localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;
  localparam int unsigned WatchLimit = 4000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic                 cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  int                   pending, fail_count, deal_count, full_count;
  int                   items_sent;
  bit                   calm;       // no idling on either side in the last part
  bit                   hold_req;   // asks the receiver for one long hold-off
  logic [62:0]          recent_tid;

  order_log_level_book_and_deal_detect_top u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  olb_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .pending_o(pending), .fail_count_o(fail_count),
    .deal_count_o(deal_count), .full_count_o(full_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Random 63-bit value covering every bit.
  function automatic logic [62:0] rand63();
    return 63'({$urandom, $urandom});
  endfunction

  // Sends one entry; the fixed payload fields not named are random.
  task automatic send_entry(logic [7:0] flags, logic [30:0] px, logic [30:0] amt,
                            logic [62:0] tid);
    s_axis_tdata <= {7'd0, rand63(), rand63(), 31'($urandom), 31'($urandom),
                     tid, amt, px, flags};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    // The valid stays high into the next item unless a gap is taken here.
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Stops offering and waits until every expected result has come back.
  // Every item causes a result, so the block is idle once all results are back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_book_enable(logic value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One random entry, mostly well-formed with a small price pool so that
  // levels build up, cancel out and deals pair up.
  task automatic send_random_entry();
    logic [7:0] flags;
    logic [30:0] px, amt;
    logic [62:0] tid;
    int pick;
    flags = $urandom_range(0, 1) ? FL_BUY : FL_SELL;
    flags |= 8'($urandom) & (FL_ADD | FL_EOT | FL_FILL);
    pick = $urandom_range(0, 19);
    if (pick == 0) flags |= FL_SESS;
    else if (pick == 1) flags |= FL_NSYS;
    else if (pick == 2) flags |= FL_REPL;
    else if (pick == 3) flags = 8'($urandom);
    else if (pick == 4) flags = (flags & ~(FL_BUY | FL_SELL)) | ($urandom_range(0, 1) ?
                                 (FL_BUY | FL_SELL) : 8'h00);
    px = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'(1000 + $urandom_range(0, 11));
    pick = $urandom_range(0, 9);
    amt = (pick == 0) ? 31'($urandom) : (pick == 1) ? MAX31 - 31'($urandom_range(0, 3)) :
          31'($urandom_range(0, 20));
    pick = $urandom_range(0, 5);
    if (pick < 2) tid = recent_tid;
    else if (pick == 2) tid = '0;
    else if (pick == 3) tid = rand63();
    else tid = 63'($urandom_range(1, 50));
    recent_tid = tid;
    send_entry(flags, px, amt, tid);
  endtask

  // Receiver: random ready bursts, one long hold-off on request, and a
  // steady ready once the run is calm.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (calm) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  // Watchdog: the run ends if nothing moves on either stream for too long.
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= WatchLimit) begin
        $display("timeout: no item moved for %0d cycles", WatchLimit);
        $display("order_log_level_book_and_deal_detect_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    recent_tid = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Book disabled after reset: only deal pairing and the quotes flag kept.
    send_entry(FL_ADD | FL_SELL | FL_EOT, 31'd10, 31'd7, 63'd5);
    send_entry(FL_BUY, 31'd10, 31'd7, 63'd5);
    send_entry(FL_BUY | FL_SELL, 31'd10, 31'd7, 63'd5);
    drain();

    // Directed part with the book on.
    write_book_enable(1'b1);
    send_entry(FL_ADD | FL_SELL, 31'd100, 31'd5, '0);
    send_entry(FL_ADD | FL_BUY, 31'd100, 31'd5, '0);      // level goes to zero
    send_entry(FL_BUY, 31'd200, MAX31, 63'd9);
    send_entry(FL_BUY, 31'd200, MAX31, 63'd9);              // deal, saturates high
    send_entry(FL_ADD | FL_BUY, 31'd300, MAX31, '0);
    send_entry(FL_ADD | FL_BUY, 31'd300, MAX31, '0);        // saturates low
    send_entry(FL_ADD | FL_BUY, 31'd300, 31'd2, '0);
    send_entry(FL_SELL, 31'd400, 31'd0, '0);                // zero for absent price
    send_entry(FL_ADD | FL_SELL | FL_EOT, MAX31, MAX31, '1);
    send_entry(FL_ADD | FL_SELL | FL_NSYS, 31'd0, 31'd1, '1); // ignored, quotes flag kept
    send_entry(FL_ADD | FL_BUY | FL_REPL, 31'd0, 31'd1, '1);
    send_entry(FL_ADD, 31'd0, 31'd1, '1);                   // neither side
    send_entry(FL_SELL | FL_BUY | FL_SESS, 31'd0, 31'd1, '1); // clears the table
    send_entry(FL_ADD | FL_SELL | FL_FILL, 31'd200, 31'd3, '1); // deal across ignored
    send_entry(FL_SELL, 31'd0, 31'd4, '0);
    send_entry(FL_SELL, 31'd0, 31'd4, '0);                  // zero ids never pair
    drain();

    // Fill the table past its size, then keep hitting it while full.
    send_entry(FL_SESS | FL_ADD | FL_SELL, 31'd5000, 31'd1, '0);
    for (int i = 1; i < PriceLevels + 6; i++)
      send_entry(FL_ADD | FL_SELL, 31'(5000 + i), 31'd1, '0);
    for (int i = 0; i < 60; i++) send_random_entry();

    // Long receiver hold-off while the sender keeps offering.
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_random_entry();
    drain();

    // Random part, with the book off in phases 1 and 4 and on in the others.
    for (int phase = 0; phase < 6; phase++) begin
      write_book_enable(phase % 3 != 1);
      if (phase == 5) calm = 1'b1;
      for (int i = 0; i < 190; i++) begin
        send_random_entry();
        if (i == 95 && phase == 2) drain();   // sender pause mid-phase
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("Sent %0d order-log items across book on/off phases; %0d deals, %0d full-table drops.",
             items_sent, deal_count, full_count);
    if (fail_count == 0) begin
      $display("order_log_level_book_and_deal_detect_top regression: pass");
    end else begin
      $display("%0d mismatches found", fail_count);
      $display("order_log_level_book_and_deal_detect_top regression: fail");
    end
    $finish;
  end

endmodule
